FILE: rtl/core/tpsrch_pkg.sv
// shared types, register codes and helpers for the two-pattern stream search
package tpsrch_pkg;

  localparam int MAX_PAT_LEN = 8;
  localparam int BYTE_W      = 8;
  localparam int PAT_W       = MAX_PAT_LEN * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int POS_W       = $clog2(MAX_PAT_LEN);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int STATUS_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_PATTERN = 3'd0,
    REG_TARGET_LENGTH  = 3'd1,
    REG_TERM_PATTERN   = 3'd2,
    REG_TERM_LENGTH    = 3'd3,
    REG_USE_TERM       = 3'd4
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_SEARCHING  = 2'd0,
    STATUS_TARGET     = 2'd1,
    STATUS_TERMINATOR = 2'd2,
    STATUS_TIMEOUT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_TSCAN  = 2'd1,
    S_ESCAN  = 2'd2,
    S_FINISH = 2'd3
  } ctrl_state_t;

  typedef struct packed {
    logic [PAT_W-1:0] target_pattern;
    logic [LEN_W-1:0] target_length;
    logic [PAT_W-1:0] term_pattern;
    logic [LEN_W-1:0] term_length;
    logic             use_term;
  } cfg_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_PAT_LEN)) ? LEN_W'(MAX_PAT_LEN) : len;
  endfunction

  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                 input logic [POS_W-1:0] idx);
    return pat[idx * BYTE_W +: BYTE_W];
  endfunction

endpackage

FILE: rtl/core/tpsrch_cand.sv
// shared candidate compare unit: tests one fallback position of one pattern
module tpsrch_cand (
  input  logic [tpsrch_pkg::PAT_W-1:0]  pat,
  input  logic [tpsrch_pkg::POS_W-1:0]  orig,
  input  logic [tpsrch_pkg::POS_W-1:0]  k,
  input  logic [tpsrch_pkg::BYTE_W-1:0] c,
  output logic                          hit
);

  always_comb begin
    logic [tpsrch_pkg::POS_W-1:0] diff;
    logic                         prefix_ok;
    diff      = orig - k;
    prefix_ok = 1'b1;
    // prefix of length k must equal the bytes it would shift onto
    for (int i = 0; i < tpsrch_pkg::MAX_PAT_LEN - 1; i++) begin
      if (tpsrch_pkg::POS_W'(i) < k &&
          tpsrch_pkg::pat_byte(pat, tpsrch_pkg::POS_W'(i)) !=
          tpsrch_pkg::pat_byte(pat, tpsrch_pkg::POS_W'(i) + diff)) begin
        prefix_ok = 1'b0;
      end
    end
    hit = prefix_ok && (c == tpsrch_pkg::pat_byte(pat, k));
  end

endmodule

FILE: rtl/core/tpsrch_ctrl.sv
// sequencer: match positions, candidate scan per pattern and result register
module tpsrch_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  tpsrch_pkg::cfg_t              cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic [tpsrch_pkg::BYTE_W-1:0] data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tpsrch_pkg::STATUS_W-1:0] status
);

  tpsrch_pkg::ctrl_state_t state, state_next;
  tpsrch_pkg::status_t     res, res_next;
  tpsrch_pkg::status_t     status_q;

  logic [tpsrch_pkg::LEN_W-1:0]  pos0, pos0_next;
  logic [tpsrch_pkg::LEN_W-1:0]  pos1, pos1_next;
  logic [tpsrch_pkg::POS_W-1:0]  k, k_next;
  logic [tpsrch_pkg::POS_W-1:0]  orig, orig_next;
  logic [tpsrch_pkg::BYTE_W-1:0] byte_q, byte_next;
  logic                          out_valid_next;

  logic [tpsrch_pkg::LEN_W-1:0]  tlen, elen, cand_len;
  logic [tpsrch_pkg::POS_W-1:0]  tstart, estart;
  logic [tpsrch_pkg::PAT_W-1:0]  scan_pat;
  logic                          hit, out_load, early_end;

  assign tlen      = tpsrch_pkg::eff_len(cfg.target_length);
  assign elen      = tpsrch_pkg::eff_len(cfg.term_length);
  // a stored position not below the length restarts from zero
  assign tstart    = (pos0 >= tlen) ? '0 : pos0[tpsrch_pkg::POS_W-1:0];
  assign estart    = (pos1 >= elen) ? '0 : pos1[tpsrch_pkg::POS_W-1:0];
  assign cand_len  = {1'b0, k} + tpsrch_pkg::LEN_W'(1);
  assign scan_pat  = (state == tpsrch_pkg::S_ESCAN) ? cfg.term_pattern
                                                    : cfg.target_pattern;
  assign out_load  = (state == tpsrch_pkg::S_FINISH) && (!out_valid || out_ready);
  assign early_end = (tlen == '0) || (cfg.use_term && elen == '0) || mode;

  tpsrch_cand u_cand (
    .pat  (scan_pat),
    .orig (orig),
    .k    (k),
    .c    (byte_q),
    .hit  (hit)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      tpsrch_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = early_end ? tpsrch_pkg::S_FINISH : tpsrch_pkg::S_TSCAN;
        end
      end
      tpsrch_pkg::S_TSCAN: begin
        if (hit && cand_len == tlen) begin
          state_next = tpsrch_pkg::S_FINISH;
        end else if (hit || k == '0) begin
          state_next = cfg.use_term ? tpsrch_pkg::S_ESCAN : tpsrch_pkg::S_FINISH;
        end
      end
      tpsrch_pkg::S_ESCAN: begin
        if (hit || k == '0) begin
          state_next = tpsrch_pkg::S_FINISH;
        end
      end
      tpsrch_pkg::S_FINISH: begin
        if (out_load) begin
          state_next = tpsrch_pkg::S_IDLE;
        end
      end
      default: state_next = tpsrch_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_ready       = (state == tpsrch_pkg::S_IDLE);
    pos0_next      = pos0;
    pos1_next      = pos1;
    k_next         = k;
    orig_next      = orig;
    byte_next      = byte_q;
    res_next       = res;
    out_valid_next = out_valid && !out_ready;
    case (state)
      tpsrch_pkg::S_IDLE: begin
        byte_next = data_byte;
        k_next    = tstart;
        orig_next = tstart;
        if (tlen == '0) begin
          res_next = tpsrch_pkg::STATUS_TARGET;
        end else if (cfg.use_term && elen == '0) begin
          res_next = tpsrch_pkg::STATUS_TERMINATOR;
        end else if (mode) begin
          res_next = tpsrch_pkg::STATUS_TIMEOUT;
        end else begin
          res_next = tpsrch_pkg::STATUS_SEARCHING;
        end
      end
      tpsrch_pkg::S_TSCAN: begin
        if (hit) begin
          pos0_next = cand_len;
          if (cand_len == tlen) res_next = tpsrch_pkg::STATUS_TARGET;
        end else if (k == '0) begin
          pos0_next = '0;
        end else begin
          k_next = k - tpsrch_pkg::POS_W'(1);
        end
        if (state_next == tpsrch_pkg::S_ESCAN) begin
          k_next    = estart;
          orig_next = estart;
        end
      end
      tpsrch_pkg::S_ESCAN: begin
        if (hit) begin
          pos1_next = cand_len;
          if (cand_len == elen) res_next = tpsrch_pkg::STATUS_TERMINATOR;
        end else if (k == '0) begin
          pos1_next = '0;
        end else begin
          k_next = k - tpsrch_pkg::POS_W'(1);
        end
      end
      tpsrch_pkg::S_FINISH: begin
        if (out_load) begin
          out_valid_next = 1'b1;
          if (res != tpsrch_pkg::STATUS_SEARCHING) begin
            pos0_next = '0;
            pos1_next = '0;
          end
          if (!cfg.use_term) pos1_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tpsrch_pkg::S_IDLE;
      pos0      <= '0;
      pos1      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos0      <= pos0_next;
      pos1      <= pos1_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    orig   <= orig_next;
    byte_q <= byte_next;
    res    <= res_next;
    if (out_load) status_q <= res;
  end

  assign status = status_q;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != tpsrch_pkg::S_IDLE)
    else $error("accepted beat did not start work");

  a_scan_k_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == tpsrch_pkg::S_TSCAN || state == tpsrch_pkg::S_ESCAN) |-> k <= orig)
    else $error("candidate above starting position");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    out_load && res != tpsrch_pkg::STATUS_SEARCHING |=> pos0 == '0 && pos1 == '0)
    else $error("positions not cleared at end of search");

  a_idle_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == tpsrch_pkg::S_IDLE |->
      pos0 < tpsrch_pkg::LEN_W'(tpsrch_pkg::MAX_PAT_LEN) &&
      pos1 < tpsrch_pkg::LEN_W'(tpsrch_pkg::MAX_PAT_LEN))
    else $error("stored position reached full length");
`endif

endmodule

FILE: rtl/core/stream_two_pattern_search_core.sv
// top level: configuration registers and the pattern search sequencer
//
// Watches a byte stream for a target string and, optionally, a terminator string
// of up to eight bytes each, and returns one status beat per input beat
// (searching, target found, terminator found, timed out). One beat is in work at
// a time and in_ready is low meanwhile. A beat is accepted in the idle state,
// the shared candidate compare unit tests up to eight fallback positions of the
// target and up to eight of the terminator (one per cycle, from the current
// match position down to zero), then the result register is loaded once the
// output is free. Zero-length patterns and timeouts skip the scan. The result
// register lets the next beat in while a status beat still waits. The user must
// write configuration (cfg_we/cfg_index/cfg_data) only while idle; not enforced.
module stream_two_pattern_search_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [tpsrch_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tpsrch_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [tpsrch_pkg::BYTE_W-1:0]     data_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [tpsrch_pkg::STATUS_W-1:0]   status
);

  tpsrch_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        tpsrch_pkg::REG_TARGET_PATTERN: cfg.target_pattern <= cfg_data;
        tpsrch_pkg::REG_TARGET_LENGTH:
          cfg.target_length <= cfg_data[tpsrch_pkg::LEN_W-1:0];
        tpsrch_pkg::REG_TERM_PATTERN:   cfg.term_pattern <= cfg_data;
        tpsrch_pkg::REG_TERM_LENGTH:
          cfg.term_length <= cfg_data[tpsrch_pkg::LEN_W-1:0];
        tpsrch_pkg::REG_USE_TERM:       cfg.use_term <= cfg_data[0];
        default: ;
      endcase
    end
  end

  tpsrch_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status)
  );

endmodule
